[rtl/char_lcd_nibble_sequencer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character-LCD nibble sequencer
// Concurrent checks on clk_i / rst_ni; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
// Generic form with an explicit clock and active-low reset.
`define LCDNS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Default form on the block clock and reset.
`define LCDNS_ASSERT(lbl, prop, msg) \
  `LCDNS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define LCDNS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define LCDNS_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, constants and the init table of the character-LCD nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_CMD     = 3'd1,
    OP_CHAR    = 3'd2,
    OP_CURSOR  = 3'd3,
    OP_BL_ON   = 3'd4,
    OP_BL_OFF  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_BYTE = 2'd1,
    JOB_BL   = 2'd2
  } job_kind_e;

  // Three expander writes per nibble.
  typedef enum logic [1:0] {
    PH_DATA    = 2'd0,
    PH_EN_HIGH = 2'd1,
    PH_EN_LOW  = 2'd2
  } phase_e;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic       CMD_SET_DDRAM  = 1'b1;   // bit 7 of set-cursor command
  localparam logic [6:0] ROW1_BASE      = 7'h40;

  localparam int unsigned BIT_RS = 0;
  localparam int unsigned BIT_EN = 2;
  localparam int unsigned BIT_BL = 3;

  localparam logic [5:0] INIT_DELAY_MS  = 6'd50;
  localparam logic [2:0] ENABLE_HOLD_MS = 3'd1;
  localparam logic [2:0] CLEAR_EXTRA_MS = 3'd2;

  localparam int unsigned INIT_STEPS = 12;  // nibbles in the init sequence
  localparam int unsigned BYTE_STEPS = 2;   // nibbles in one byte
  localparam int unsigned NIB_W      = $clog2(INIT_STEPS);

  localparam int unsigned JOB_FIFO_DEPTH = 2;
  localparam int unsigned JOB_FIFO_PTR_W = $clog2(JOB_FIFO_DEPTH);
  localparam int unsigned JOB_FIFO_CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
    logic       rs;
    logic [2:0] extra;
    logic       bl_on;
  } job_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic [5:0] delay_before_ms;
    logic [2:0] delay_after_ms;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [2:0] extra;
  } init_step_t;

  // Init: wake-up nibbles 3,3,3,2, then commands 0x28, 0x0C, 0x01, 0x06
  // as high/low nibble pairs. Clear gets its extra wait on its low nibble.
  function automatic init_step_t init_step(input logic [NIB_W-1:0] idx);
    init_step_t s;
    s = '{nibble: 4'h0, extra: 3'd0};
    case (idx)
      4'd0:    s = '{nibble: 4'h3, extra: 3'd5};
      4'd1:    s = '{nibble: 4'h3, extra: 3'd5};
      4'd2:    s = '{nibble: 4'h3, extra: 3'd1};
      4'd3:    s = '{nibble: 4'h2, extra: 3'd1};
      4'd4:    s = '{nibble: 4'h2, extra: 3'd0};
      4'd5:    s = '{nibble: 4'h8, extra: 3'd0};
      4'd6:    s = '{nibble: 4'h0, extra: 3'd0};
      4'd7:    s = '{nibble: 4'hC, extra: 3'd0};
      4'd8:    s = '{nibble: 4'h0, extra: 3'd0};
      4'd9:    s = '{nibble: 4'h1, extra: CLEAR_EXTRA_MS};
      4'd10:   s = '{nibble: 4'h0, extra: 3'd0};
      4'd11:   s = '{nibble: 4'h6, extra: 3'd0};
      default: s = '{nibble: 4'h0, extra: 3'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/lcdns_if.sv]
// ----------------------------------------------------------------------------
// lcdns channel interfaces
// Operation channel in, expander byte channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdns_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] value;
  logic       row;
  logic [5:0] column;

  modport source (output valid, operation, value, row, column, input ready);
  modport sink   (input valid, operation, value, row, column, output ready);
endinterface

interface lcdns_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic [5:0] delay_before_ms;
  logic [2:0] delay_after_ms;
  logic       last;

  modport source (output valid, expander_byte, delay_before_ms, delay_after_ms, last,
                  input ready);
  modport sink   (input valid, expander_byte, delay_before_ms, delay_after_ms, last,
                  output ready);
endinterface

`default_nettype wire

[rtl/lcdns_front.sv]
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts LCD operations and turns them into jobs for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_front (
  lcdns_cmd_if.sink        cmd_i,
  input  logic             full_i,
  output logic             push_o,
  output lcdns_pkg::job_t  job_o
);
  import lcdns_pkg::*;

  logic       known;
  logic [6:0] cursor_addr;

  assign cmd_i.ready = !full_i;

  // Row base plus column, wrapped to 7 bits.
  assign cursor_addr = (cmd_i.row ? ROW1_BASE : 7'h00) + {1'b0, cmd_i.column};

  always_comb begin
    known = 1'b1;
    job_o = '{kind: JOB_BYTE, data: cmd_i.value, rs: 1'b0, extra: 3'd0, bl_on: 1'b0};
    case (op_e'(cmd_i.operation))
      OP_INIT: begin
        job_o.kind = JOB_INIT;
      end
      OP_CMD: begin
        if (cmd_i.value == CMD_CLEAR || cmd_i.value == CMD_HOME) begin
          job_o.extra = CLEAR_EXTRA_MS;
        end
      end
      OP_CHAR: begin
        job_o.rs = 1'b1;
      end
      OP_CURSOR: begin
        job_o.data = {CMD_SET_DDRAM, cursor_addr};
      end
      OP_BL_ON: begin
        job_o.kind  = JOB_BL;
        job_o.bl_on = 1'b1;
      end
      OP_BL_OFF: begin
        job_o.kind  = JOB_BL;
        job_o.bl_on = 1'b0;
      end
      default: begin
        known = 1'b0;  // drop undefined codes
      end
    endcase
  end

  assign push_o = cmd_i.valid && cmd_i.ready && known;

endmodule

`default_nettype wire

[rtl/lcdns_fifo.sv]
// ----------------------------------------------------------------------------
// lcdns_fifo
// Short job queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcdns_pkg::job_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lcdns_pkg::job_t  pop_data_o
);
  import lcdns_pkg::*;

  job_t                      mem_q [JOB_FIFO_DEPTH];
  logic [JOB_FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [JOB_FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [JOB_FIFO_CNT_W-1:0] count_q, count_d;
  logic                      do_push, do_pop;

  assign full_o     = (count_q == JOB_FIFO_CNT_W'(JOB_FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JOB_FIFO_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0
                 : wr_ptr_q + JOB_FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JOB_FIFO_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0
                 : rd_ptr_q + JOB_FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + JOB_FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - JOB_FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/lcdns_back.sv]
// ----------------------------------------------------------------------------
// lcdns_back
// Byte sequencer: expands jobs into expander writes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_sequencer_core_macros.svh"

module lcdns_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  lcdns_pkg::job_t  head_i,
  output logic             pop_o,
  lcdns_byte_if.source     byte_o
);
  import lcdns_pkg::*;

  job_t             job_q, job_d;
  logic             active_q, active_d;
  logic [NIB_W-1:0] nib_q, nib_d;
  phase_e           phase_q, phase_d;
  logic             bl_q, bl_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  job_t       cur;
  logic       emit;
  logic       last;
  logic [3:0] nib_data;
  logic [2:0] extra;
  logic       rs;
  init_step_t step;
  out_t       beat;

  assign cur  = active_q ? job_q : head_i;
  assign emit = (active_q || head_valid_i) && (!out_valid_q || byte_o.ready);
  assign step = init_step(nib_q);

  // Output side: build the current expander write.
  always_comb begin
    nib_data = 4'h0;
    extra    = 3'd0;
    rs       = 1'b0;
    last     = 1'b0;
    beat     = '{expander_byte: 8'h00, delay_before_ms: 6'd0, delay_after_ms: 3'd0,
                 last: 1'b0};
    unique case (cur.kind)
      JOB_INIT: begin
        nib_data = step.nibble;
        extra    = step.extra;
        last     = (nib_q == NIB_W'(INIT_STEPS - 1)) && (phase_q == PH_EN_LOW);
        if (nib_q == '0 && phase_q == PH_DATA) begin
          beat.delay_before_ms = INIT_DELAY_MS;
        end
      end
      JOB_BYTE: begin
        nib_data = nib_q[0] ? cur.data[3:0] : cur.data[7:4];
        extra    = nib_q[0] ? cur.extra : 3'd0;
        rs       = cur.rs;
        last     = (nib_q == NIB_W'(BYTE_STEPS - 1)) && (phase_q == PH_EN_LOW);
      end
      JOB_BL: begin
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase

    if (cur.kind == JOB_BL) begin
      beat.expander_byte[BIT_BL] = cur.bl_on;
    end else begin
      beat.expander_byte[7:4]    = nib_data;
      beat.expander_byte[BIT_BL] = bl_q;
      beat.expander_byte[BIT_EN] = (phase_q == PH_EN_HIGH);
      beat.expander_byte[BIT_RS] = rs;
      unique case (phase_q)
        PH_DATA:    beat.delay_after_ms = 3'd0;
        PH_EN_HIGH: beat.delay_after_ms = ENABLE_HOLD_MS;
        PH_EN_LOW:  beat.delay_after_ms = ENABLE_HOLD_MS + extra;
        default:    beat.delay_after_ms = 3'd0;
      endcase
    end
    beat.last = last;
  end

  // Next state: walk nibbles and phases, take a job off the queue on its first write.
  always_comb begin
    job_d       = job_q;
    active_d    = active_q;
    nib_d       = nib_q;
    phase_d     = phase_q;
    bl_d        = bl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = emit && !active_q;

    if (emit) begin
      out_d       = beat;
      out_valid_d = 1'b1;
      if (cur.kind == JOB_BL) begin
        bl_d = cur.bl_on;
      end
      if (last) begin
        active_d = 1'b0;
        nib_d    = '0;
        phase_d  = PH_DATA;
      end else begin
        active_d = 1'b1;
        if (!active_q) begin
          job_d = head_i;
        end
        unique case (phase_q)
          PH_DATA:    phase_d = PH_EN_HIGH;
          PH_EN_HIGH: phase_d = PH_EN_LOW;
          PH_EN_LOW: begin
            phase_d = PH_DATA;
            nib_d   = nib_q + NIB_W'(1);
          end
          default:    phase_d = PH_DATA;
        endcase
      end
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      nib_q       <= '0;
      phase_q     <= PH_DATA;
      bl_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      nib_q       <= nib_d;
      phase_q     <= phase_d;
      bl_q        <= bl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign byte_o.valid           = out_valid_q;
  assign byte_o.expander_byte   = out_q.expander_byte;
  assign byte_o.delay_before_ms = out_q.delay_before_ms;
  assign byte_o.delay_after_ms  = out_q.delay_after_ms;
  assign byte_o.last            = out_q.last;

  `LCDNS_ASSERT(a_en_high_hold, out_valid_q && out_q.expander_byte[BIT_EN] |-> out_q.delay_after_ms == ENABLE_HOLD_MS, "enable-high write without its 1 ms hold")
  `LCDNS_ASSERT(a_lead_wait_first, out_valid_q && out_q.delay_before_ms != 6'd0 |-> !out_q.last && !out_q.expander_byte[BIT_EN], "lead wait on a write other than the first")
  `LCDNS_ASSERT(a_idle_counters, !active_q |-> nib_q == '0 && phase_q == PH_DATA, "sequencer idle with counters not cleared")
  `LCDNS_ASSERT(a_last_ends_job, emit && last |=> !active_q, "sequencer still busy after a final write")

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character-LCD operations to 4-bit port-expander write sequences.
// ----------------------------------------------------------------------------
// Each accepted operation is expanded into expander bytes, one byte per clock
// while the byte channel takes them: init gives 36 bytes, command, write
// character and set cursor give 6, backlight on/off gives 1, and codes 6 and
// 7 are accepted and dropped. The back-end sequencer that produces one write
// per cycle sets the throughput; a two-entry job queue in front of it lets
// operations be taken while earlier ones are still being expanded, so cmd_i
// stays ready until the queue holds two jobs. Output bytes leave a register,
// in the cycle after the sequencer reaches them.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_sequencer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcdns_cmd_if.sink     cmd_i,
  lcdns_byte_if.source  byte_o
);
  import lcdns_pkg::*;

  logic full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  lcdns_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  lcdns_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .pop_data_o  (head_job)
  );

  lcdns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .byte_o       (byte_o)
  );

endmodule

`default_nettype wire

[dv/char_lcd_nibble_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_tb
// Sends LCD operations through the command channel and checks every expander
// write against an in-bench expansion of the operation. A short directed
// table comes first, then a longer random part. Both channels stall at
// random, with one long back-pressure stretch and a full drain mid-run.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_tb;
  import lcdns_pkg::*;

  typedef enum logic [1:0] {
    FROM_MODEL = 2'd0,
    NO_BYTES   = 2'd1,
    ONE_BYTE   = 2'd2
  } chk_src_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic       row;
    logic [5:0] column;
    chk_src_e   src;
    out_t       typed;
  } dir_row_t;

  localparam logic [2:0] OP_UNDEF_6 = 3'd6;
  localparam logic [2:0] OP_UNDEF_7 = 3'd7;

  localparam logic [7:0] RS_MASK = 8'h01 << BIT_RS;
  localparam logic [7:0] EN_MASK = 8'h01 << BIT_EN;
  localparam logic [7:0] BL_MASK = 8'h01 << BIT_BL;

  localparam logic [7:0] WAKE_NIBBLE    = 8'h30;
  localparam logic [7:0] FOUR_BIT_NIB   = 8'h20;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [2:0] WAKE_LONG_MS   = 3'd5;
  localparam logic [2:0] WAKE_SHORT_MS  = 3'd1;

  localparam out_t NO_WRITE      = '0;
  localparam out_t BL_OFF_WRITE  = '{8'h00, 6'd0, 3'd0, 1'b1};
  localparam out_t BL_ON_WRITE   = '{8'h08, 6'd0, 3'd0, 1'b1};

  localparam int N_DIR      = 25;
  localparam int RAND_ITEMS = 120;
  localparam int DRAIN_AT   = 64;
  localparam int HOLD_AT    = 32;
  localparam int LONG_HOLD  = 300;
  localparam int CALM_AT    = 100;
  localparam int TAIL_CYC   = 40;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_BL_OFF,  8'h00, 1'b0, 6'd0,  ONE_BYTE,   BL_OFF_WRITE},
    '{OP_BL_ON,   8'h00, 1'b0, 6'd0,  ONE_BYTE,   BL_ON_WRITE},
    '{OP_INIT,    8'h00, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CMD,     8'h01, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CMD,     8'h02, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CMD,     8'h00, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CMD,     8'hFF, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CMD,     8'h03, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CHAR,    8'h01, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CHAR,    8'h02, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CHAR,    8'h00, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CHAR,    8'hFF, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CURSOR,  8'h00, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CURSOR,  8'h00, 1'b0, 6'd63, FROM_MODEL, NO_WRITE},
    '{OP_CURSOR,  8'h00, 1'b1, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CURSOR,  8'h00, 1'b1, 6'd39, FROM_MODEL, NO_WRITE},
    '{OP_CURSOR,  8'h00, 1'b1, 6'd63, FROM_MODEL, NO_WRITE},
    '{OP_UNDEF_6, 8'hFF, 1'b1, 6'd63, NO_BYTES,   NO_WRITE},
    '{OP_UNDEF_7, 8'h00, 1'b0, 6'd0,  NO_BYTES,   NO_WRITE},
    '{OP_BL_OFF,  8'h00, 1'b0, 6'd0,  ONE_BYTE,   BL_OFF_WRITE},
    '{OP_BL_OFF,  8'hFF, 1'b1, 6'd63, ONE_BYTE,   BL_OFF_WRITE},
    '{OP_CMD,     8'h01, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_INIT,    8'h00, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_CHAR,    8'h5A, 1'b0, 6'd0,  FROM_MODEL, NO_WRITE},
    '{OP_BL_ON,   8'h00, 1'b0, 6'd0,  ONE_BYTE,   BL_ON_WRITE}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lcdns_cmd_if  cmd_if ();
  lcdns_byte_if byte_if ();

  char_lcd_nibble_sequencer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .byte_o (byte_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  out_t        lcd_writes_due [$];
  out_t        op_writes [$];
  logic        bl_lit = 1'b1;
  int unsigned err_cnt = 0;
  int unsigned rand_sent = 0;
  bit          calm = 1'b0;
  bit          held = 1'b0;
  int unsigned tx_pct = 0;

  // ---- expansion of one operation into expander writes ----

  function automatic void put_write(input logic [7:0] b, input logic [5:0] wait_pre,
                                    input logic [2:0] wait_post);
    out_t w;
    w.expander_byte   = b | (bl_lit ? BL_MASK : 8'h00);
    w.delay_before_ms = wait_pre;
    w.delay_after_ms  = wait_post;
    w.last            = 1'b0;
    op_writes.push_back(w);
  endfunction

  // Data, enable high, enable low; the extra wait follows the falling enable.
  function automatic void put_nibble(input logic [7:0] d, input logic [5:0] wait_pre,
                                     input logic [2:0] extra);
    put_write(d, wait_pre, 3'd0);
    put_write(d | EN_MASK, 6'd0, ENABLE_HOLD_MS);
    put_write(d & ~EN_MASK, 6'd0, 3'(ENABLE_HOLD_MS + extra));
  endfunction

  function automatic void put_byte(input logic [7:0] v, input logic rs,
                                   input logic [2:0] extra);
    logic [7:0] rs_bits;
    rs_bits = rs ? RS_MASK : 8'h00;
    put_nibble({v[7:4], 4'h0} | rs_bits, 6'd0, 3'd0);
    put_nibble({v[3:0], 4'h0} | rs_bits, 6'd0, extra);
  endfunction

  function automatic void put_cmd(input logic [7:0] c);
    put_byte(c, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ? CLEAR_EXTRA_MS : 3'd0);
  endfunction

  function automatic void expand_op(input logic [2:0] op, input logic [7:0] value,
                                    input logic row, input logic [5:0] column);
    logic [6:0] addr;
    int         tail;
    op_writes.delete();
    case (op)
      OP_INIT: begin
        put_nibble(WAKE_NIBBLE, INIT_DELAY_MS, WAKE_LONG_MS);
        put_nibble(WAKE_NIBBLE, 6'd0, WAKE_LONG_MS);
        put_nibble(WAKE_NIBBLE, 6'd0, WAKE_SHORT_MS);
        put_nibble(FOUR_BIT_NIB, 6'd0, WAKE_SHORT_MS);
        put_cmd(CMD_FUNC_SET);
        put_cmd(CMD_DISPLAY_ON);
        put_cmd(CMD_CLEAR);
        put_cmd(CMD_ENTRY_MODE);
      end
      OP_CMD:    put_cmd(value);
      OP_CHAR:   put_byte(value, 1'b1, 3'd0);
      OP_CURSOR: begin
        addr = (row ? ROW1_BASE : 7'h00) + 7'(column);
        put_cmd({CMD_SET_DDRAM, addr});
      end
      OP_BL_ON: begin
        bl_lit = 1'b1;
        put_write(8'h00, 6'd0, 3'd0);
      end
      OP_BL_OFF: begin
        bl_lit = 1'b0;
        put_write(8'h00, 6'd0, 3'd0);
      end
      default: ;
    endcase
    tail = op_writes.size() - 1;
    if (tail >= 0) op_writes[tail].last = 1'b1;
  endfunction

  // ---- command channel ----

  task automatic send_op(input logic [2:0] op, input logic [7:0] value, input logic row,
                         input logic [5:0] column, input chk_src_e src, input out_t typed);
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.value     <= value;
    cmd_if.row       <= row;
    cmd_if.column    <= column;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    expand_op(op, value, row, column);
    case (src)
      FROM_MODEL: foreach (op_writes[k]) lcd_writes_due.push_back(op_writes[k]);
      ONE_BYTE:   lcd_writes_due.push_back(typed);
      default:    ;
    endcase
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < tx_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every outstanding write has arrived.
  task automatic drain_writes();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (lcd_writes_due.size() != 0);
  endtask

  initial begin
    logic [2:0]  op;
    logic [7:0]  value;
    logic        row;
    logic [5:0]  column;
    int unsigned pick;
    int unsigned issued;
    bit          drained_mid;

    drained_mid      = 1'b0;
    issued           = 0;
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.operation <= OP_INIT;
    cmd_if.value     <= 8'h00;
    cmd_if.row       <= 1'b0;
    cmd_if.column    <= 6'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_pct = 20;
    for (int i = 0; i < N_DIR; i++) begin
      send_op(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].row, DIR_ROWS[i].column,
              DIR_ROWS[i].src, DIR_ROWS[i].typed);
      sender_gap();
    end
    drain_writes();

    while (rand_sent < RAND_ITEMS) begin
      if (issued % 20 == 0) tx_pct = $urandom_range(0, 2) * 25;
      if (!drained_mid && rand_sent == DRAIN_AT) begin
        drain_writes();
        drained_mid = 1'b1;
      end
      calm = (rand_sent >= CALM_AT);

      pick = $urandom_range(0, 99);
      if (pick < 4)       op = OP_INIT;
      else if (pick < 34) op = OP_CMD;
      else if (pick < 64) op = OP_CHAR;
      else if (pick < 84) op = OP_CURSOR;
      else if (pick < 90) op = OP_BL_ON;
      else if (pick < 95) op = OP_BL_OFF;
      else                op = $urandom_range(0, 1) ? OP_UNDEF_7 : OP_UNDEF_6;
      value = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME)
                                          : 8'($urandom_range(0, 255));
      row    = 1'($urandom_range(0, 1));
      column = 6'($urandom_range(0, 63));

      send_op(op, value, row, column, FROM_MODEL, NO_WRITE);
      issued++;
      if (op <= OP_BL_OFF) rand_sent++;
      sender_gap();
    end

    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (lcd_writes_due.size() != 0);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---- byte channel ----

  initial begin
    int unsigned cyc;
    int unsigned stall_pct;
    cyc       = 0;
    stall_pct = 0;
    byte_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      cyc++;
      if (cyc % 64 == 0) stall_pct = $urandom_range(0, 2) * 20;
      if (!held && rand_sent >= HOLD_AT) begin
        // long back-pressure: the job queue fills and the command side stalls
        byte_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        byte_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        byte_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic note_diff(input string fld, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (lcd_writes_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transfer, expected none, actual byte 0x%0h",
                 $time, byte_if.expander_byte);
      end else begin
        want = lcd_writes_due.pop_front();
        note_diff("expander_byte", want.expander_byte, byte_if.expander_byte);
        note_diff("delay_before_ms", want.delay_before_ms, byte_if.delay_before_ms);
        note_diff("delay_after_ms", want.delay_after_ms, byte_if.delay_after_ms);
        note_diff("last", want.last, byte_if.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[char_lcd_nibble_sequencer_core.f]
+incdir+rtl
rtl/lcdns_pkg.sv
rtl/lcdns_if.sv
rtl/lcdns_front.sv
rtl/lcdns_fifo.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer_core.sv
dv/char_lcd_nibble_sequencer_core_tb.sv
